[hdl/itrd_pkg.sv]
// Shared types, constants and helpers for the integer to radix digit converter.
`timescale 1ns / 1ps

package itrd_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 7;
    localparam int BASE_W     = 6;
    localparam int PAD_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int MAX_CHARS  = 64;
    localparam int ADDR_W     = 6;
    localparam int COUNT_W    = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [BASE_W-1:0]    t_base;
    typedef logic [PAD_W-1:0]     t_pad;

    localparam t_cfg_idx CFG_BASE = 2'd0;
    localparam t_cfg_idx CFG_PAD  = 2'd1;

    localparam t_base BASE_RESET = 6'd10;
    localparam t_base BASE_MIN   = 6'd2;
    localparam t_base BASE_MAX   = 6'd36;
    localparam t_pad  PAD_RESET  = 7'd0;
    localparam t_pad  PAD_MAX    = 7'd64;

    localparam t_base DIGIT_LIMIT = 6'd10;
    localparam t_char CHAR_ZERO   = 7'd48;
    localparam t_char CHAR_A      = 7'd65;

    function automatic t_char digit_char(input t_base d);
        if (d < DIGIT_LIMIT) begin
            return CHAR_ZERO + {1'b0, d};
        end
        return CHAR_A + {1'b0, d - DIGIT_LIMIT};
    endfunction

endpackage

[hdl/itrd_in_if.sv]
// Input channel: one value to convert per transfer.
`timescale 1ns / 1ps

interface itrd_in_if
    import itrd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[hdl/itrd_out_if.sv]
// Output channel: one digit character per transfer.
`timescale 1ns / 1ps

interface itrd_out_if
    import itrd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_char char_code;
    logic  last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

[hdl/integer_to_radix_digits.sv]
// Each digit is produced by dividing the value in CHUNKS chunks of 8 bits (CHUNKS = VALUE_BITS/8
// rounded up); each character is then read from the digit store (S_RD) and offered (S_OUT).
// The shared divider retires 8 quotient bits a cycle.
// One value is in flight at a time; input ready is high only while idle.
// Synchronous active-low reset returns to idle with base 10 and no padding.
`timescale 1ns / 1ps

module integer_to_radix_digits
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    itrd_in_if.sink               i_in,
    itrd_out_if.source            o_out
);

    localparam int STEP   = 8;
    localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
    localparam int DIV_W  = CHUNKS * STEP;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         r_state;
    t_base              r_cfg_base;
    t_pad               r_cfg_pad;
    t_base              r_b;
    t_pad               r_pad;
    logic [DIV_W-1:0]   r_quot;
    t_base              r_rem;
    logic [CW-1:0]      r_chunk;
    logic [COUNT_W-1:0] r_n;
    logic [ADDR_W-1:0]  r_k;
    t_char              r_rd;
    logic               r_pad_sel;

    t_char              mem [MAX_CHARS];

    logic [DIV_W-1:0]   n_quot;
    t_base              n_rem;
    logic [COUNT_W-1:0] n_total;
    t_base              eff_base;
    t_pad               eff_pad;
    logic               last_chunk;

    always_comb begin
        logic [STEP-1:0] qbits;
        logic [BASE_W:0] trial;
        t_base           rem;
        rem   = r_rem;
        qbits = '0;
        for (int i = 0; i < STEP; i++) begin
            trial = {rem, r_quot[DIV_W-1-i]};
            qbits[STEP-1-i] = (trial >= {1'b0, r_b});
            if (qbits[STEP-1-i]) begin
                trial = trial - {1'b0, r_b};
            end
            rem = trial[BASE_W-1:0];
        end
        n_rem  = rem;
        n_quot = (r_quot << STEP) | DIV_W'(qbits);
    end

    always_comb begin
        if (r_cfg_base < BASE_MIN) begin
            eff_base = BASE_MIN;
        end else if (r_cfg_base > BASE_MAX) begin
            eff_base = BASE_MAX;
        end else begin
            eff_base = r_cfg_base;
        end
        eff_pad = (r_cfg_pad > PAD_MAX) ? PAD_MAX : r_cfg_pad;
    end

    always_comb begin
        if (r_n == '0 && r_pad == '0) begin
            n_total = COUNT_W'(1);
        end else if (r_n > r_pad) begin
            n_total = r_n;
        end else begin
            n_total = r_pad;
        end
    end

    assign last_chunk = (r_chunk == CW'(CHUNKS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base <= BASE_RESET;
            r_cfg_pad  <= PAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE: r_cfg_base <= i_cfg_data[BASE_W-1:0];
                CFG_PAD:  r_cfg_pad  <= i_cfg_data[PAD_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chunk <= '0;
            r_n     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_DIV;
                        r_chunk <= '0;
                        r_n     <= '0;
                    end
                end
                S_DIV: begin
                    if (r_chunk == '0 && r_quot == '0) begin
                        r_k     <= ADDR_W'(n_total - COUNT_W'(1));
                        r_state <= S_RD;
                    end else if (last_chunk) begin
                        r_chunk <= '0;
                        r_n     <= r_n + COUNT_W'(1);
                    end else begin
                        r_chunk <= r_chunk + CW'(1);
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        if (r_k == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k - ADDR_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: dividend, remainder and latched settings
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_quot <= DIV_W'(i_in.value[VALUE_BITS-1:0]);
            r_rem  <= '0;
            r_b    <= eff_base;
            r_pad  <= eff_pad;
        end else if (r_state == S_DIV && !(r_chunk == '0 && r_quot == '0)) begin
            r_quot <= n_quot;
            r_rem  <= last_chunk ? '0 : n_rem;
        end
    end

    // Digit store, least significant digit at address 0
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && last_chunk) begin
            mem[r_n[ADDR_W-1:0]] <= digit_char(n_rem);
        end
        if (r_state == S_RD) begin
            r_rd      <= mem[r_k];
            r_pad_sel <= ({1'b0, r_k} >= r_n);
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.char_code = r_pad_sel ? CHAR_ZERO : r_rd;
    assign o_out.last      = (r_k == '0);

endmodule

[hdl/itrd_checker.sv]
// Port-level assertions for the radix digit converter, bound to the top level.
`timescale 1ns / 1ps

module itrd_checker
    import itrd_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_char i_out_char,
    input logic  i_out_last
);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a character is offered");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after an input transfer");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (i_in_ready && !i_out_valid))
        else $error("not idle after the final character");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_char >= 7'd48 && i_out_char <= 7'd57)
                      || (i_out_char >= 7'd65 && i_out_char <= 7'd90)))
        else $error("character outside digit set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_char)
                                           && $stable(i_out_last)))
        else $error("offered character changed before transfer");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_code),
    .i_out_last  (o_out.last)
);

[tb/sv/integer_to_radix_digits_checker.sv]
// Checker for the radix digit converter: predicts each value's characters and compares transfers.
`timescale 1ns / 1ps

module integer_to_radix_digits_checker
    import itrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    itrd_in_if                    i_in,
    itrd_out_if                   i_out,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_char_count
);

    typedef struct packed {
        t_char char_code;
        logic  last;
    } char_xfer_t;

    t_base      base_cfg;
    t_pad       pad_cfg;
    char_xfer_t expected_chars[$];
    char_xfer_t want;
    int         fail_count;
    int         pending;
    int         char_count;

    initial begin
        base_cfg   = BASE_RESET;
        pad_cfg    = PAD_RESET;
        fail_count = 0;
        pending    = 0;
        char_count = 0;
    end

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_char_count = char_count;

    // Division yields digits least significant first, so they are queued in reverse.
    function automatic void expand_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] rem;
        int unsigned        width;
        t_char              lsd_first[$];
        char_xfer_t         x;
        rest  = value;
        radix = (base_cfg < BASE_MIN) ? VALUE_W'(BASE_MIN) :
                (base_cfg > BASE_MAX) ? VALUE_W'(BASE_MAX) : VALUE_W'(base_cfg);
        width = (pad_cfg > PAD_MAX) ? PAD_MAX : pad_cfg;
        while (rest != 0) begin
            rem = rest % radix;
            if (rem < DIGIT_LIMIT) begin
                lsd_first.push_back(CHAR_ZERO + t_char'(rem));
            end else begin
                lsd_first.push_back(CHAR_A + t_char'(rem - DIGIT_LIMIT));
            end
            rest = rest / radix;
        end
        if (lsd_first.size() == 0 && width == 0) begin
            lsd_first.push_back(CHAR_ZERO);
        end
        while (lsd_first.size() < width) begin
            lsd_first.push_back(CHAR_ZERO);
        end
        for (int i = lsd_first.size() - 1; i >= 0; i--) begin
            x.char_code = lsd_first[i];
            x.last      = (i == 0);
            expected_chars.push_back(x);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_cfg = BASE_RESET;
            pad_cfg  = PAD_RESET;
        end else begin
            if (i_in.valid && i_in.ready) begin
                expand_digits(i_in.value);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE: base_cfg = i_cfg_data[BASE_W-1:0];
                    CFG_PAD:  pad_cfg  = i_cfg_data[PAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                char_count++;
                if (expected_chars.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("[%0t] unexpected transfer: char 0x%02h last %0b", $realtime,
                                 i_out.char_code, i_out.last);
                    end
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out.char_code !== want.char_code || i_out.last !== want.last) begin
                        if (fail_count < 10) begin
                            $display("[%0t] mismatch: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                                     $realtime, want.char_code, i_out.char_code, want.last,
                                     i_out.last);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_chars.size();
    end

endmodule

[tb/sv/integer_to_radix_digits_tb.sv]
// Top of the radix digit converter testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module integer_to_radix_digits_tb;
    import itrd_pkg::*;

    localparam t_cfg_idx CFG_UNUSED_2 = 2'd2;
    localparam t_cfg_idx CFG_UNUSED_3 = 2'd3;
    localparam int       HOLD_CYCLES  = 400;
    localparam int       TAIL_CYCLES  = 700;
    localparam int       CYCLE_LIMIT  = 3_000_000;
    localparam int       PHASES       = 14;
    localparam int       PHASE_ITEMS  = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int send_idle_pct = 13;
    int recv_idle_pct = 51;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int values_sent   = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;
    int chk_fail_count;
    int chk_pending;
    int chk_char_count;

    itrd_in_if  in_ch ();
    itrd_out_if out_ch ();

    integer_to_radix_digits uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    integer_to_radix_digits_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_char_count (chk_char_count)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] raw;
        int unsigned        len;
        raw = {$urandom, $urandom};
        len = $urandom_range(1, VALUE_W);
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'($urandom_range(0, 40));
            default: return raw >> (VALUE_W - len);
        endcase
    endfunction

    // Called and returns at a falling edge; valid stays high for back-to-back transfers.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        values_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] p);
        drain();
        write_reg(CFG_BASE, b);
        write_reg(CFG_PAD, p);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int phase;
        logic [CFG_DATA_W-1:0] b;
        logic [CFG_DATA_W-1:0] p;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_BASE;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: defaults, base and padding extremes, saturation, unused indexes
        send_value('0);
        send_value('1);
        send_value(64'd1);
        send_value(64'd10);
        configure(7'd2, 7'd0);
        send_value('1);
        send_value('0);
        send_value(64'h8000_0000_0000_0000);
        configure(7'd36, 7'd0);
        send_value('1);
        send_value(64'd35);
        send_value(64'd36);
        configure(7'd0, 7'd0);
        send_value(64'd5);
        configure(7'd1, 7'd0);
        send_value(64'd5);
        configure(7'd37, 7'd0);
        send_value(64'd35);
        configure(7'd63, 7'd0);
        send_value(64'd71);
        configure(7'h4A, 7'd0);
        send_value(64'd123);
        configure(7'd10, 7'd64);
        send_value('0);
        send_value(64'd12345);
        configure(7'd16, 7'd127);
        send_value('0);
        send_value('1);
        configure(7'd16, 7'd5);
        send_value(64'hABC);
        drain();
        write_reg(CFG_UNUSED_2, 7'h7F);
        write_reg(CFG_UNUSED_3, 7'h03);
        i_cfg_we = 1'b0;
        send_value(64'd255);

        // Random phases, each with its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 5) begin
                send_idle_pct = 13;
                recv_idle_pct = 51;
            end else if (phase < 10) begin
                send_idle_pct = 51;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0:       b = CFG_DATA_W'($urandom_range(0, 1));
                1:       b = CFG_DATA_W'($urandom_range(37, 127));
                default: b = CFG_DATA_W'($urandom_range(2, 36));
            endcase
            case ($urandom_range(9))
                6, 7:    p = CFG_DATA_W'($urandom_range(1, 24));
                8:       p = CFG_DATA_W'(PAD_MAX);
                9:       p = CFG_DATA_W'($urandom_range(65, 127));
                default: p = '0;
            endcase
            configure(b, p);
            if ($urandom_range(3) == 0) begin
                write_reg($urandom_range(1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                          CFG_DATA_W'($urandom));
                i_cfg_we = 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 4 && (phase == 1 || phase == 11)) begin
                    hold_req++;
                end
                if (k == 15 && phase == 3) begin
                    drain();
                end
                send_value(pick_value());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Converted %0d values into %0d characters over %0d register writes,",
                 values_sent, chk_char_count, reg_writes);
        $display("bases 2 to 36 with saturation, padding 0 to 64, stalls on both sides.");
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
